/* rtl/core/gost2_pkg.sv */
// package: s-box rows, round function and beat types for the two-block gost cipher
package gost2_pkg;

   localparam int NumRounds = 32;
   localparam int NumStages = 2 * NumRounds;
   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
        4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
      '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
        4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
      '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
        4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
      '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
        4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
      '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
        4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
      '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
        4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
      '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
        4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
      '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
        4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
   };

   typedef struct packed {
      logic        command;
      logic [63:0] first_block;
      logic [63:0] second_block;
   } req_type;

   typedef struct packed {
      logic [63:0] first_result;
      logic [63:0] second_result;
   } rsp_type;

   typedef struct packed {
      logic        command;
      logic [63:0] b0;
      logic [63:0] b1;
      logic [63:0] r0;
      logic [31:0] n1;
      logic [31:0] n2;
   } stage_type;

   function automatic logic [31:0] round_f(input logic [31:0] v);
      logic [31:0] s;
      for (int k = 0; k < 8; k++) begin
         s[4*k +: 4] = SBOX[k][v[4*k +: 4]];
      end
      return {s[20:0], s[31:21]};
   endfunction

endpackage

/* rtl/core/gost89_two_block_cipher.sv */
// top level: 64-stage pipelined two-block gost 28147-89 unit cipher
// one feistel round per stage; each req beat is registered in every stage on its way to rsp
// throughput: one unit per cycle; the whole pipe holds while rsp is stalled
// first 32 stages run the first block, the last 32 run the second block
// reset: synchronous, clears valid bits and the key registers to zero
module gost89_two_block_cipher
   import gost2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0] key_ff [4];
   logic [31:0] key_w [8];
   logic        vld_ff [NumStages];
   stage_type   st_ff [NumStages];
   logic        adv;

   assign adv = rsp_ready || !vld_ff[NumStages-1];
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         key_w[2*i]   = key_ff[i][31:0];
         key_w[2*i+1] = key_ff[i][63:32];
      end
   end

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      localparam int R = s % NumRounds;
      localparam int KiEnc = (R < 24) ? (R % 8) : (7 - (R % 8));
      localparam int KiDec = (R < 8) ? (R % 8) : (7 - (R % 8));
      stage_type   prev;
      stage_type   st_in;
      logic [63:0] blk;
      logic [31:0] k;
      logic        vld_in;

      always_comb begin
         if (s == 0) begin
            prev.command = req_data.command;
            prev.b0      = req_data.first_block;
            prev.b1      = req_data.second_block;
            prev.r0      = '0;
            prev.n1      = req_data.first_block[31:0];
            prev.n2      = req_data.first_block[63:32];
            vld_in       = req_valid;
         end else begin
            prev   = st_ff[(s == 0) ? 0 : s-1];
            vld_in = vld_ff[(s == 0) ? 0 : s-1];
         end
         st_in = prev;
         blk   = '0;
         if (s == NumRounds) begin
            // first block done: load second block
            st_in.r0 = {prev.n1, prev.n2};
            blk = (prev.command == CmdDecrypt) ? prev.b1 : (prev.b1 ^ {prev.n1, prev.n2});
            st_in.n1 = blk[31:0];
            st_in.n2 = blk[63:32];
         end
         k = (st_in.command == CmdDecrypt) ? key_w[KiDec] : key_w[KiEnc];
         if (R % 2 == 0) st_in.n2 = st_in.n2 ^ round_f(st_in.n1 + k);
         else            st_in.n1 = st_in.n1 ^ round_f(st_in.n2 + k);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in;
         end
      end
   end

   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_data.first_result = st_ff[NumStages-1].r0;
   assign rsp_data.second_result = {st_ff[NumStages-1].n1, st_ff[NumStages-1].n2}
      ^ ((st_ff[NumStages-1].command == CmdDecrypt) ? st_ff[NumStages-1].b0 : 64'd0);

endmodule

/* test/gost89_two_block_cipher_test.sv */
// testbench: gost two-block unit cipher checked beat by beat against a built-in predictor
`timescale 1ns / 1ps
module gost89_two_block_cipher_test;
   import gost2_pkg::*;

   localparam int LatencyCycles = 64;
   localparam int StallLimit = 20000;
   localparam int CsrKey01 = 0;
   localparam int CsrKey23 = 1;
   localparam int CsrKey45 = 2;
   localparam int CsrKey67 = 3;

   typedef struct {
      logic        command;
      logic [63:0] first_block;
      logic [63:0] second_block;
      logic        known;
      logic [63:0] first_result;
      logic [63:0] second_result;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [63:0] key_image [4];
   rsp_type     expected_units [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   vector_type  directed [$];

   gost89_two_block_cipher dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] substitute_rotate(input logic [31:0] v);
      logic [31:0] s;
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: s[3:0] = SBOX[0][v[3:0]];
            default: s[4*k +: 4] = SBOX[k][v[4*k +: 4]];
         endcase
      end
      return (s << 11) | (s >> 21);
   endfunction

   function automatic logic [63:0] magma_block(input logic [63:0] blk, input logic decrypt);
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] kw;
      int          ki;
      bit          ascending;
      n1 = blk[31:0];
      n2 = blk[63:32];
      for (int r = 0; r < 32; r++) begin
         ascending = decrypt ? (r < 8) : (r < 24);
         ki = ascending ? (r % 8) : (7 - (r % 8));
         kw = ki[0] ? key_image[ki / 2][63:32] : key_image[ki / 2][31:0];
         if (r % 2 == 0) begin
            n2 ^= substitute_rotate(n1 + kw);
         end else begin
            n1 ^= substitute_rotate(n2 + kw);
         end
      end
      return {n1, n2};
   endfunction

   function automatic rsp_type cipher_unit(input req_type u);
      rsp_type r;
      if (u.command == CmdEncrypt) begin
         r.first_result = magma_block(u.first_block, 1'b0);
         r.second_result = magma_block(u.second_block ^ r.first_result, 1'b0);
      end else begin
         r.second_result = magma_block(u.second_block, 1'b1) ^ u.first_block;
         r.first_result = magma_block(u.first_block, 1'b1);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic write_key(input int index, input logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index[1:0];
      csr_wdata <= value;
      key_image[index] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (expected_units.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // valid stays high after a beat until the next gap or drain
   task automatic send_unit(input req_type u, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_units.push_back(cipher_unit(u));
      req_valid <= 1'b1;
      req_data <= u;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [63:0] random_word;
      return {$urandom, $urandom};
   endfunction

   task automatic random_keys;
      for (int i = 0; i < 4; i++) write_key(i, random_word());
   endtask

   // rsp side: random stalls, compare each beat to the oldest prediction
   initial begin
      int stall;
      rsp_type want;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_units.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.first_result, 64'h0);
         end else begin
            want = expected_units.pop_front();
            if (rsp_data.first_result !== want.first_result)
               report_mismatch("first_result", rsp_data.first_result, want.first_result);
            if (rsp_data.second_result !== want.second_result)
               report_mismatch("second_result", rsp_data.second_result, want.second_result);
         end
      end
   end

   // watchdog on cycles without a beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_type u;
      vector_type v;
      logic [63:0] ones;
      ones = '1;
      for (int i = 0; i < 4; i++) key_image[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero key, directed data: expected values come only from the predictor
      directed.push_back('{CmdEncrypt, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdDecrypt, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdEncrypt, ones, ones, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdDecrypt, ones, ones, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdEncrypt, 64'h1, 64'h8000000000000000, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdDecrypt, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdEncrypt, 64'hfedcba9876543210, 64'h0123456789abcdef,
                           1'b0, 64'h0, 64'h0});
      directed.push_back('{CmdDecrypt, 64'h0123456789abcdef, 64'hfedcba9876543210,
                           1'b0, 64'h0, 64'h0});
      foreach (directed[i]) begin
         v = directed[i];
         u = '{v.command, v.first_block, v.second_block};
         send_unit(u, 1'b0);
      end
      drain();

      // extreme keys, directed again, back to back
      for (int i = 0; i < 4; i++) write_key(i, ones);
      foreach (directed[i]) begin
         v = directed[i];
         send_unit('{v.command, v.first_block, v.second_block}, 1'b1);
      end
      drain();
      write_key(CsrKey01, 64'hffeeddccbbaa9988);
      write_key(CsrKey23, 64'h7766554433221100);
      write_key(CsrKey45, 64'hf0f1f2f3f4f5f6f7);
      write_key(CsrKey67, 64'hfcfdfeff00000000);
      foreach (directed[i]) begin
         v = directed[i];
         send_unit('{v.command, v.first_block, v.second_block}, 1'b0);
      end
      drain();

      // random phases: encrypt then decrypt round trips plus random units
      for (int phase = 0; phase < 8; phase++) begin
         random_keys();
         for (int n = 0; n < 220; n++) begin
            u.command = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
               0: u.first_block = '0;
               1: u.first_block = ones;
               default: u.first_block = random_word();
            endcase
            u.second_block = random_word();
            send_unit(u, phase == 3);
            if (u.command == CmdEncrypt && $urandom_range(0, 3) == 0) begin
               u = '{CmdDecrypt, expected_units[$].first_result,
                     expected_units[$].second_result};
               send_unit(u, 1'b0);
            end
         end
         drain();
      end
      for (int i = 0; i < 4; i++) write_key(i, '0);
      send_unit('{CmdEncrypt, random_word(), random_word()}, 1'b0);
      send_unit('{CmdDecrypt, random_word(), random_word()}, 1'b0);

      drain();
      repeat (LatencyCycles + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/gost2_pkg.sv
rtl/core/gost89_two_block_cipher.sv
test/gost89_two_block_cipher_test.sv
